// File: src/three_wire_uart_tx_framer_unit_macros.svh
// ----------------------------------------------------------------------------
// three-wire uart tx framer assertion macros
// shorthand for the clocked, reset-qualified checks used at the top level
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_UART_TX_FRAMER_UNIT_MACROS_SVH
`define THREE_WIRE_UART_TX_FRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define TUF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TUF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tuf_pkg.sv
// ----------------------------------------------------------------------------
// tuf_pkg
// shared types and constants of the three-wire uart tx framer
// ----------------------------------------------------------------------------
package tuf_pkg;

  // word codes on the input channel
  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_RSVD    = 2'd3
  } action_t;

  localparam logic [7:0] SLIP_DELIM     = 8'hC0;
  localparam logic [7:0] ESC_LEAD       = 8'hDB;
  localparam logic [7:0] ESC_DELIM_CODE = 8'hDC;
  localparam logic [7:0] ESC_SELF_CODE  = 8'hDD;

  localparam logic [3:0] TYPE_ACK_PKT  = 4'h1;
  localparam logic [3:0] TYPE_HCI_CMD  = 4'h2;
  localparam logic [3:0] TYPE_ACL_DATA = 4'h4;
  localparam logic [3:0] TYPE_SCO_DATA = 4'h5;

  // back-end step codes of a header job
  localparam logic [2:0] HDR_STEP_OPEN  = 3'd0;
  localparam logic [2:0] HDR_STEP_LAST  = 3'd4;
  localparam logic [2:0] HDR_STEP_CLOSE = 3'd5;
  // back-end step codes of a payload job
  localparam logic [2:0] PAY_STEP_DATA  = 3'd0;
  localparam logic [2:0] PAY_STEP_CLOSE = 3'd1;

  localparam int QUEUE_DEPTH_DEF = 4;

  // one unit of work handed from front to back
  typedef struct packed {
    logic             is_hdr;  // header job, else payload job
    logic             close;   // closing delimiter follows
    logic [3:0][7:0]  bytes;   // header bytes, or payload byte in entry 0
  } job_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == SLIP_DELIM) || (b == ESC_LEAD);
  endfunction

  function automatic logic type_reliable(input logic [3:0] t);
    return (t == TYPE_ACK_PKT) || (t == TYPE_HCI_CMD) ||
           (t == TYPE_ACL_DATA) || (t == TYPE_SCO_DATA);
  endfunction

endpackage

// File: src/tuf_front.sv
// ----------------------------------------------------------------------------
// tuf_front
// accepts input words, tracks packet state and builds header or payload jobs
// ----------------------------------------------------------------------------
module tuf_front import tuf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_pkt_type,
  input  logic [11:0] in_pkt_len,
  input  logic [2:0]  in_ack_num,
  input  logic [7:0]  in_data_byte,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [2:0]  seq_r, seq_nxt;
  logic [11:0] left_r, left_nxt;
  logic        open_r, open_nxt;

  logic        acc;
  logic        rel;
  logic [7:0]  h0, h1, h2, h3;
  logic [11:0] left_dec;
  action_t     act;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign act      = action_t'(in_action);

  assign rel      = type_reliable(in_pkt_type);
  assign h0       = {rel, 1'b0, in_ack_num, (rel ? seq_r : 3'd0)};
  assign h1       = {in_pkt_len[3:0], in_pkt_type};
  assign h2       = in_pkt_len[11:4];
  assign h3       = ~(h0 + h1 + h2);
  assign left_dec = left_r - 12'd1;

  always_comb begin
    seq_nxt  = seq_r;
    left_nxt = left_r;
    open_nxt = open_r;
    q_push   = 1'b0;
    q_job    = '0;
    if (acc) begin
      case (act)
        ACT_START: begin
          q_push       = 1'b1;
          q_job.is_hdr = 1'b1;
          q_job.close  = (in_pkt_len == 12'd0);
          q_job.bytes  = {h3, h2, h1, h0};
          if (rel) begin
            seq_nxt = seq_r + 3'd1;
          end
          open_nxt = (in_pkt_len != 12'd0);
          left_nxt = in_pkt_len;
        end
        ACT_PAYLOAD: begin
          if (open_r) begin
            q_push         = 1'b1;
            q_job.close    = (left_dec == 12'd0);
            q_job.bytes[0] = in_data_byte;
            left_nxt       = left_dec;
            open_nxt       = (left_dec != 12'd0);
          end
        end
        ACT_CLEAR: begin
          seq_nxt = 3'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= 3'd0;
      left_r <= 12'd0;
      open_r <= 1'b0;
    end else begin
      seq_r  <= seq_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

// File: src/tuf_queue.sv
// ----------------------------------------------------------------------------
// tuf_queue
// small first-in first-out queue of jobs between front and back
// ----------------------------------------------------------------------------
module tuf_queue import tuf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output job_t head_job
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  job_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LAST_IDX) ? '0 : wr_r + AW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST_IDX) ? '0 : rd_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: src/tuf_back.sv
// ----------------------------------------------------------------------------
// tuf_back
// walks the head job one line byte per cycle unless the output stalls, slip-escaping
// ----------------------------------------------------------------------------
module tuf_back import tuf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_frame_end
);

  logic [2:0] step_r, step_nxt;
  logic       esc_r, esc_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       last_r, last_nxt;
  logic       fe_r, fe_nxt;

  logic       fire;
  logic       is_open, is_close, is_final_data;
  logic [1:0] bidx;
  logic [7:0] cur;
  logic       done;

  assign fire          = job_valid && (!ov_r || out_ready);
  assign is_open       = job.is_hdr && (step_r == HDR_STEP_OPEN);
  assign is_close      = job.is_hdr ? (step_r == HDR_STEP_CLOSE) : (step_r == PAY_STEP_CLOSE);
  assign is_final_data = job.is_hdr ? (step_r == HDR_STEP_LAST) : (step_r == PAY_STEP_DATA);
  // header steps 1..4 pick header bytes 0..3
  assign bidx          = job.is_hdr ? (step_r[1:0] - 2'd1) : 2'd0;
  assign cur           = job.bytes[bidx];

  always_comb begin
    step_nxt = step_r;
    esc_nxt  = esc_r;
    ov_nxt   = ov_r && !out_ready;
    ob_nxt   = ob_r;
    last_nxt = last_r;
    fe_nxt   = fe_r;
    done     = 1'b0;
    job_pop  = 1'b0;
    if (fire) begin
      ov_nxt   = 1'b1;
      last_nxt = 1'b0;
      fe_nxt   = 1'b0;
      if (is_open || is_close) begin
        ob_nxt = SLIP_DELIM;
        fe_nxt = is_close;
        done   = 1'b1;
      end else if (needs_escape(cur) && !esc_r) begin
        ob_nxt  = ESC_LEAD;
        esc_nxt = 1'b1;
      end else begin
        if (esc_r) begin
          ob_nxt = (cur == SLIP_DELIM) ? ESC_DELIM_CODE : ESC_SELF_CODE;
        end else begin
          ob_nxt = cur;
        end
        esc_nxt = 1'b0;
        done    = 1'b1;
      end
      if (done) begin
        if (is_close || (is_final_data && !job.close)) begin
          job_pop  = 1'b1;
          last_nxt = 1'b1;
          step_nxt = 3'd0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      esc_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      step_r <= step_nxt;
      esc_r  <= esc_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r   <= ob_nxt;
    last_r <= last_nxt;
    fe_r   <= fe_nxt;
  end

  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign out_run_last  = last_r;
  assign out_frame_end = fe_r;

endmodule

// File: src/three_wire_uart_tx_framer_unit.sv
// ----------------------------------------------------------------------------
// three_wire_uart_tx_framer_unit
// three-wire uart (h5) transmit framer: delimits, builds headers, slip-escapes
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): one word per accepted handshake. a start
// word opens a packet and yields the opening 0xc0, four escaped header bytes
// and, for zero length, the closing 0xc0. a payload word yields its escaped
// byte and, on the last counted byte, the closing 0xc0. payload words with no
// open packet, clear words and the unused code give no output.
// output channel (out_valid/out_ready): one line byte per word, out_run_last
// marks the final byte caused by an input word, out_frame_end the closing
// delimiter.
// with the queue empty, an accepted word is written into the queue and the back
// end then loads its first byte into the output register; it emits one line byte
// per cycle unless the receiver stalls it. the front takes one word per cycle as
// long as the job queue (QUEUE_DEPTH entries) has room. reset: sequence counter
// zero, no packet open, queue and output register empty. when the receiver
// stalls, the output register holds its byte, the back end stops, the queue
// fills and then in_ready drops.
// ----------------------------------------------------------------------------
`include "three_wire_uart_tx_framer_unit_macros.svh"

module three_wire_uart_tx_framer_unit import tuf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // job queue entries, 2 and up
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_pkt_type,
  input  logic [11:0] in_pkt_len,
  input  logic [2:0]  in_ack_num,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_frame_end
);

  // front to queue
  logic q_push;
  job_t q_job;
  logic q_full;
  // queue to back
  logic q_nonempty;
  job_t q_head;
  logic q_pop;

  // front: classify words, hold sequence and length state, build jobs
  tuf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_pkt_type  (in_pkt_type),
    .in_pkt_len   (in_pkt_len),
    .in_ack_num   (in_ack_num),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  // decoupling queue so a stalled line does not stall classification
  tuf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_job (q_head)
  );

  // back: serialize and escape, registered output
  tuf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (q_nonempty),
    .job           (q_head),
    .job_pop       (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

  // the front never pushes into a full queue
  `TUF_ASSERT_SAME(a_no_overflow, q_push, !q_full, "job pushed into full queue")

  // a closing delimiter is a delimiter and ends the run of its input word
  `TUF_ASSERT_SAME(a_close_is_last, out_valid && out_frame_end,
                   out_byte == SLIP_DELIM && out_run_last,
                   "closing delimiter malformed")

  // an escape byte is always followed at once by its second half
  `TUF_ASSERT_NEXT(a_escape_pair,
                   out_valid && out_ready && out_byte == ESC_LEAD && !out_run_last,
                   out_valid && (out_byte == ESC_DELIM_CODE || out_byte == ESC_SELF_CODE),
                   "escape byte not followed by escape code")

  // the queue only drains through the back end when it holds a job
  `TUF_ASSERT_SAME(a_pop_nonempty, q_pop, q_nonempty, "pop from empty queue")

endmodule

// File: bench/tb_three_wire_uart_tx_framer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_wire_uart_tx_framer_unit
// self-checking bench for the three-wire uart tx framer: a directed table of
// words, then random packets under four idling phases, every line byte
// compared against a behavioral model of the framer kept in this file
// ----------------------------------------------------------------------------
module tb_three_wire_uart_tx_framer_unit;
  import tuf_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int IDLE_LIMIT = 4000;
  // quiet cycles after the last byte
  localparam int DRAIN_CYCLES = 16;

  // one word on the input channel
  typedef struct packed {
    action_t     act;
    logic [3:0]  ptype;
    logic [11:0] plen;
    logic [2:0]  ack;
    logic [7:0]  data;
  } word_t;

  // one byte on the serial side, with its markers
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       fend;
  } line_t;

  // row of the directed table; exp_n < 0 means the model decides
  typedef struct packed {
    word_t           w;
    int              exp_n;
    logic            exp_close;
    logic [0:9][7:0] exp_b;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [3:0]  in_pkt_type;
  logic [11:0] in_pkt_len;
  logic [2:0]  in_ack_num;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_frame_end;

  three_wire_uart_tx_framer_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_pkt_type  (in_pkt_type),
    .in_pkt_len   (in_pkt_len),
    .in_ack_num   (in_ack_num),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_frame_end(out_frame_end)
  );

  // model state of the framer
  logic [2:0]  mdl_seq;
  logic [11:0] mdl_left;
  logic        mdl_open;

  line_t frame_bytes[$];   // bytes caused by the word just accepted
  line_t line_q[$];        // bytes still owed by the block, oldest first
  row_t  dir_tab[$];

  int    errs;
  int    idle_pct;         // sender gap chance per cycle, percent
  int    stall_pct;        // receiver stall chance per cycle, percent
  int    busy_words;       // random words that produced line bytes
  int    quiet_cnt;
  line_t mon_exp;

  // --------------------------------------------------------------------------
  // clock and receiver back-pressure
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // out_ready is redrawn at every falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // --------------------------------------------------------------------------
  // framer model
  // --------------------------------------------------------------------------
  function automatic void push_line(input logic [7:0] b, input logic fend);
    line_t l;
    l.b = b;
    l.last = 1'b0;
    l.fend = fend;
    frame_bytes.push_back(l);
  endfunction

  // slip stuffing: delimiter and escape each become a two-byte sequence
  function automatic void push_stuffed(input logic [7:0] b);
    if (b == SLIP_DELIM) begin
      push_line(ESC_LEAD, 1'b0);
      push_line(ESC_DELIM_CODE, 1'b0);
    end else if (b == ESC_LEAD) begin
      push_line(ESC_LEAD, 1'b0);
      push_line(ESC_SELF_CODE, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  function automatic void frame_word(input word_t w);
    logic [7:0] h0, h1, h2, h3;
    frame_bytes.delete();
    case (w.act)
      ACT_START: begin
        h0 = {2'b00, w.ack, 3'b000};
        // reliable types carry and advance the sequence number
        if (w.ptype == TYPE_ACK_PKT || w.ptype == TYPE_HCI_CMD ||
            w.ptype == TYPE_ACL_DATA || w.ptype == TYPE_SCO_DATA) begin
          h0[7] = 1'b1;
          h0[2:0] = mdl_seq;
          mdl_seq = mdl_seq + 3'd1;
        end
        h1 = {w.plen[3:0], w.ptype};
        h2 = w.plen[11:4];
        h3 = ~(h0 + h1 + h2);
        push_line(SLIP_DELIM, 1'b0);
        push_stuffed(h0);
        push_stuffed(h1);
        push_stuffed(h2);
        push_stuffed(h3);
        if (w.plen == 12'd0) begin
          push_line(SLIP_DELIM, 1'b1);
          mdl_open = 1'b0;
          mdl_left = 12'd0;
        end else begin
          // any packet still open is dropped without a closing delimiter
          mdl_open = 1'b1;
          mdl_left = w.plen;
        end
      end
      ACT_PAYLOAD: begin
        // stray payload with no packet open is silently dropped
        if (mdl_open) begin
          push_stuffed(w.data);
          mdl_left = mdl_left - 12'd1;
          if (mdl_left == 12'd0) begin
            push_line(SLIP_DELIM, 1'b1);
            mdl_open = 1'b0;
          end
        end
      end
      ACT_CLEAR: mdl_seq = 3'd0;
      default: ;
    endcase
    if (frame_bytes.size() > 0) frame_bytes[frame_bytes.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  // called at a falling edge, returns at the falling edge after acceptance;
  // exp_n >= 0 puts the typed-in bytes in place of the model's
  task automatic send_word(input word_t w, input int exp_n, input logic exp_close,
                           input logic [0:9][7:0] exp_b);
    line_t l;
    int i;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= w.act;
    in_pkt_type  <= w.ptype;
    in_pkt_len   <= w.plen;
    in_ack_num   <= w.ack;
    in_data_byte <= w.data;
    do @(posedge clk); while (!in_ready);
    frame_word(w);
    if (frame_bytes.size() > 0) busy_words++;
    if (exp_n < 0) begin
      foreach (frame_bytes[i]) line_q.push_back(frame_bytes[i]);
    end else begin
      for (i = 0; i < exp_n; i++) begin
        l.b = exp_b[i];
        l.last = (i == exp_n - 1);
        l.fend = (i == exp_n - 1) && exp_close;
        line_q.push_back(l);
      end
    end
    @(negedge clk);
  endtask

  // sender holds off until every owed byte is out, then a few quiet cycles
  task automatic quiesce();
    in_valid <= 1'b0;
    while (line_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_row(input action_t a, input logic [3:0] t, input logic [11:0] len,
                         input logic [2:0] ack, input logic [7:0] d, input int n,
                         input logic close, input logic [0:9][7:0] bytes);
    row_t r;
    r.w.act = a;
    r.w.ptype = t;
    r.w.plen = len;
    r.w.ack = ack;
    r.w.data = d;
    r.exp_n = n;
    r.exp_close = close;
    r.exp_b = bytes;
    dir_tab.push_back(r);
  endtask

  // fully random word: any code, any field, stray payload included
  task automatic noise_word();
    word_t w;
    w.act = action_t'($urandom_range(3));
    w.ptype = 4'($urandom_range(15));
    w.plen = 12'($urandom_range(4095));
    w.ack = 3'($urandom_range(7));
    w.data = 8'($urandom_range(255));
    send_word(w, -1, 1'b0, '0);
  endtask

  // one well-formed packet with random content, sometimes cut short
  task automatic random_packet();
    word_t w;
    int n_pay;
    int i;
    if ($urandom_range(99) < 15) noise_word();
    w.act = ACT_START;
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(3))
        0: w.ptype = TYPE_ACK_PKT;
        1: w.ptype = TYPE_HCI_CMD;
        2: w.ptype = TYPE_ACL_DATA;
        default: w.ptype = TYPE_SCO_DATA;
      endcase
    end else begin
      w.ptype = 4'($urandom_range(15));
    end
    case ($urandom_range(19))
      0, 1: w.plen = 12'd0;
      2, 3: w.plen = 12'($urandom_range(4095));  // long packet, abandoned early
      default: w.plen = 12'($urandom_range(1, 6));
    endcase
    w.ack = 3'($urandom_range(7));
    w.data = 8'($urandom_range(255));
    send_word(w, -1, 1'b0, '0);
    n_pay = (w.plen > 12'd6) ? $urandom_range(1, 4) : int'(w.plen);
    if (n_pay > 0 && $urandom_range(99) < 15) n_pay = $urandom_range(n_pay - 1);
    for (i = 0; i < n_pay; i++) begin
      w.act = ACT_PAYLOAD;
      w.ptype = 4'($urandom_range(15));
      w.plen = 12'($urandom_range(4095));
      w.ack = 3'($urandom_range(7));
      // lean on the two bytes that need stuffing
      case ($urandom_range(9))
        0, 1: w.data = SLIP_DELIM;
        2: w.data = ESC_LEAD;
        default: w.data = 8'($urandom_range(255));
      endcase
      send_word(w, -1, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (line_q.size() == 0) begin
        $error("unexpected line byte %02h run_last %0b frame_end %0b",
               out_byte, out_run_last, out_frame_end);
        errs++;
      end else begin
        mon_exp = line_q.pop_front();
        if (out_byte !== mon_exp.b) begin
          $error("out_byte expected %02h actual %02h", mon_exp.b, out_byte);
          errs++;
        end
        if (out_run_last !== mon_exp.last) begin
          $error("out_run_last expected %0b actual %0b", mon_exp.last, out_run_last);
          errs++;
        end
        if (out_frame_end !== mon_exp.fend) begin
          $error("out_frame_end expected %0b actual %0b", mon_exp.fend, out_frame_end);
          errs++;
        end
      end
    end
  end

  // watchdog: any handshake on either side counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int ph;
    int goal;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_CLEAR;
    in_pkt_type = 4'd0;
    in_pkt_len = 12'd0;
    in_ack_num = 3'd0;
    in_data_byte = 8'd0;
    out_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    errs = 0;
    busy_words = 0;
    quiet_cnt = 0;
    mdl_seq = 3'd0;
    mdl_left = 12'd0;
    mdl_open = 1'b0;

    // bytes read straight off the framing rules right after reset
    add_row(ACT_START, 4'h0, 12'h000, 3'd0, 8'h00, 6, 1'b1,
            {8'hC0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hC0, 32'h0});
    // payload with nothing open, reserved code and clear give no bytes
    add_row(ACT_PAYLOAD, 4'hF, 12'hFFF, 3'd7, 8'hFF, 0, 1'b0, '0);
    add_row(ACT_RSVD, 4'hF, 12'hFFF, 3'd7, 8'hFF, 0, 1'b0, '0);
    add_row(ACT_CLEAR, 4'hF, 12'hFFF, 3'd7, 8'hFF, 0, 1'b0, '0);
    // reliable header with sequence zero and top ack number
    add_row(ACT_START, TYPE_ACK_PKT, 12'h001, 3'd7, 8'h00, 5, 1'b0,
            {8'hC0, 8'hB8, 8'h11, 8'h00, 8'h36, 40'h0});
    // delimiter as payload gets stuffed, then the packet closes
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, SLIP_DELIM, 3, 1'b1,
            {ESC_LEAD, ESC_DELIM_CODE, SLIP_DELIM, 56'h0});
    add_row(ACT_START, TYPE_HCI_CMD, 12'h003, 3'd0, 8'h00, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, ESC_LEAD, -1, 1'b0, '0);
    // clear in mid-packet must not close it
    add_row(ACT_CLEAR, 4'h0, 12'h000, 3'd0, 8'h00, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, 8'h00, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, 8'hFF, -1, 1'b0, '0);
    // longest length, then abandoned by the next start
    add_row(ACT_START, 4'hF, 12'hFFF, 3'd7, 8'h00, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, 8'h7E, -1, 1'b0, '0);
    add_row(ACT_START, TYPE_ACL_DATA, 12'h002, 3'd3, 8'h00, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, 8'h55, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, 8'hAA, -1, 1'b0, '0);
    add_row(ACT_START, TYPE_SCO_DATA, 12'h000, 3'd1, 8'h00, -1, 1'b0, '0);
    // length bytes that collide with the delimiter and the escape
    add_row(ACT_START, 4'h3, 12'hC00, 3'd0, 8'h00, -1, 1'b0, '0);
    add_row(ACT_START, 4'h0, 12'hDBC, 3'd0, 8'h00, -1, 1'b0, '0);
    // checksum byte comes out as the delimiter
    add_row(ACT_START, 4'hF, 12'h003, 3'd0, 8'h00, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, 8'h01, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, 8'h02, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, 8'h03, -1, 1'b0, '0);
    add_row(ACT_PAYLOAD, 4'h0, 12'h000, 3'd0, 8'h00, -1, 1'b0, '0);

    // reset once, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[r])
      send_word(dir_tab[r].w, dir_tab[r].exp_n, dir_tab[r].exp_close, dir_tab[r].exp_b);

    // phases: no idling, sender gaps, receiver stalls, both
    busy_words = 0;
    for (ph = 0; ph < 4; ph++) begin
      quiesce();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      goal = 44 * (ph + 1);
      while (busy_words < goal) random_packet();
    end

    // drain everything owed, then a few quiet cycles for stray bytes
    quiesce();
    if (line_q.size() != 0) begin
      $error("%0d line bytes never arrived", line_q.size());
      errs++;
    end
    if (errs == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
